FILE: design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/mrfe_pkg.sv
`default_nettype none

package mrfe_pkg;

  localparam int MAX_FRAME_DEF = 256;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [1:0] OP_RX     = 2'd0;
  localparam logic [1:0] OP_GAP    = 2'd1;
  localparam logic [1:0] OP_TX     = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] KIND_RX_BYTE   = 3'd0;
  localparam logic [2:0] KIND_GOOD      = 3'd1;
  localparam logic [2:0] KIND_CRC_ERR   = 3'd2;
  localparam logic [2:0] KIND_TX_BYTE   = 3'd3;
  localparam logic [2:0] KIND_TX_REJECT = 3'd4;
  localparam logic [2:0] KIND_OVERRUN   = 3'd5;

  // one queued request: its first result, plus two crc bytes when triple is set
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [8:0]  len;
    logic [15:0] err;
    logic        triple;
    logic [15:0] crc;
  } rec_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/mrfe_queue.sv
`default_nettype none

module mrfe_queue #(
  parameter int DEPTH = mrfe_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mrfe_pkg::rec_t push_data,
  output logic               full,
  input  wire logic          pop,
  output mrfe_pkg::rec_t     pop_data,
  output logic               empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  mrfe_pkg::rec_t slots_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign pop_data = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/mrfe_front.sv
`default_nettype none

module mrfe_front #(
  parameter int MAX_FRAME = mrfe_pkg::MAX_FRAME_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wen,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic        q_full,
  output logic             q_push,
  output mrfe_pkg::rec_t   q_data
);

  localparam logic [8:0] MAX_CNT = 9'(MAX_FRAME);

  logic [7:0]  slave_addr_r;
  logic [15:0] crc_r, crc_nxt;
  logic [8:0]  rx_count_r, rx_count_nxt;
  logic        addressed_r, addressed_nxt;
  logic [7:0]  older_r, older_nxt;
  logic [7:0]  newer_r, newer_nxt;
  logic        tx_allowed_r, tx_allowed_nxt;
  logic        tx_active_r, tx_active_nxt;
  logic        rx_blocked_r, rx_blocked_nxt;
  logic        overrun_r, overrun_nxt;
  logic [15:0] fail_r, fail_nxt;
  logic        emit;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && emit;

  always_comb begin
    logic [8:0]  cnt;
    logic [15:0] crc;
    logic        addr;
    crc_nxt        = crc_r;
    rx_count_nxt   = rx_count_r;
    addressed_nxt  = addressed_r;
    older_nxt      = older_r;
    newer_nxt      = newer_r;
    tx_allowed_nxt = tx_allowed_r;
    tx_active_nxt  = tx_active_r;
    rx_blocked_nxt = rx_blocked_r;
    overrun_nxt    = overrun_r;
    fail_nxt       = fail_r;
    emit           = 1'b0;
    q_data         = '0;
    cnt            = rx_count_r;
    crc            = crc_r;
    addr           = addressed_r;

    unique case (opcode)
      mrfe_pkg::OP_RX: begin
        if (!rx_blocked_r) begin
          tx_allowed_nxt = 1'b0;
          if (cnt == 9'd0) begin
            // address byte screens the frame
            if (data_byte == 8'd0 || data_byte == slave_addr_r) begin
              addr = 1'b1;
              crc  = mrfe_pkg::CRC_INIT;
            end else begin
              addr = 1'b0;
              cnt  = 9'd1;
            end
          end
          if (addr) begin
            if (cnt >= MAX_CNT) begin
              overrun_nxt = 1'b1;
              emit        = 1'b1;
              q_data.kind = mrfe_pkg::KIND_OVERRUN;
            end else begin
              // crc trails two bytes so the received crc never gets folded in
              if (cnt > 9'd1) begin
                crc = mrfe_pkg::crc16_byte(crc, older_r);
              end
              older_nxt   = newer_r;
              newer_nxt   = data_byte;
              cnt         = cnt + 9'd1;
              emit        = 1'b1;
              q_data.kind = mrfe_pkg::KIND_RX_BYTE;
              q_data.data = data_byte;
            end
          end
          addressed_nxt = addr;
          rx_count_nxt  = cnt;
          crc_nxt       = crc;
        end
      end
      mrfe_pkg::OP_GAP: begin
        if (addressed_r && overrun_r) begin
          emit        = 1'b1;
          q_data.kind = mrfe_pkg::KIND_OVERRUN;
          q_data.len  = rx_count_r;
        end else if (addressed_r && rx_count_r > 9'd2) begin
          emit       = 1'b1;
          q_data.len = rx_count_r;
          if ({newer_r, older_r} == crc_r) begin
            q_data.kind = mrfe_pkg::KIND_GOOD;
          end else begin
            fail_nxt    = fail_r + 16'd1;
            q_data.kind = mrfe_pkg::KIND_CRC_ERR;
          end
        end
        rx_count_nxt   = 9'd0;
        addressed_nxt  = 1'b0;
        overrun_nxt    = 1'b0;
        tx_allowed_nxt = 1'b1;
        tx_active_nxt  = 1'b0;
        rx_blocked_nxt = 1'b0;
      end
      mrfe_pkg::OP_TX: begin
        emit = 1'b1;
        if (!tx_active_r && !tx_allowed_r) begin
          q_data.kind = mrfe_pkg::KIND_TX_REJECT;
        end else begin
          if (!tx_active_r) begin
            tx_allowed_nxt = 1'b0;
            rx_blocked_nxt = 1'b1;
            crc            = mrfe_pkg::CRC_INIT;
          end
          crc           = mrfe_pkg::crc16_byte(crc, data_byte);
          crc_nxt       = crc;
          tx_active_nxt = !last_byte;
          q_data.kind   = mrfe_pkg::KIND_TX_BYTE;
          q_data.data   = data_byte;
          q_data.triple = last_byte;
          q_data.crc    = crc;
        end
      end
      default: begin
      end
    endcase
    q_data.err = fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'd1;
      crc_r        <= mrfe_pkg::CRC_INIT;
      rx_count_r   <= '0;
      addressed_r  <= 1'b0;
      older_r      <= '0;
      newer_r      <= '0;
      tx_allowed_r <= 1'b0;
      tx_active_r  <= 1'b0;
      rx_blocked_r <= 1'b1;
      overrun_r    <= 1'b0;
      fail_r       <= '0;
    end else begin
      if (cfg_wen) begin
        slave_addr_r <= cfg_wdata;
      end
      if (accept) begin
        crc_r        <= crc_nxt;
        rx_count_r   <= rx_count_nxt;
        addressed_r  <= addressed_nxt;
        older_r      <= older_nxt;
        newer_r      <= newer_nxt;
        tx_allowed_r <= tx_allowed_nxt;
        tx_active_r  <= tx_active_nxt;
        rx_blocked_r <= rx_blocked_nxt;
        overrun_r    <= overrun_nxt;
        fail_r       <= fail_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/mrfe_back.sv
`default_nettype none

module mrfe_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  wire mrfe_pkg::rec_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       kind,
  output logic [7:0]       out_byte,
  output logic [8:0]       frame_length,
  output logic [15:0]      error_total,
  output logic             end_mark
);

  mrfe_pkg::rec_t cur_r;
  logic           have_r;
  logic [1:0]     idx_r;
  logic           last_res;
  logic           done;

  assign last_res = !cur_r.triple || (idx_r == 2'd2);
  assign done     = have_r && out_ready && last_res;
  assign q_pop    = !q_empty && (!have_r || done);

  assign out_valid    = have_r;
  assign kind         = cur_r.kind;
  assign frame_length = cur_r.len;
  assign error_total  = cur_r.err;
  assign end_mark     = last_res;

  always_comb begin
    unique case (idx_r)
      2'd1:    out_byte = cur_r.crc[7:0];
      2'd2:    out_byte = cur_r.crc[15:8];
      default: out_byte = cur_r.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      idx_r  <= '0;
    end else if (q_pop) begin
      have_r <= 1'b1;
      idx_r  <= '0;
    end else if (done) begin
      have_r <= 1'b0;
      idx_r  <= '0;
    end else if (have_r && out_ready) begin
      // walk through the appended crc bytes
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

`default_nettype wire

FILE: design/modbus_rtu_frame_engine.sv
// Modbus RTU slave framer with a shared CRC-16 (poly 0xA001, init 0xFFFF).
// in_*: one request per handshake. in_tuser = opcode (0 line byte, 1 silence
//   gap, 2 outgoing byte), in_tdata = byte, in_tlast = final outgoing byte.
// out_*: result stream. out_tuser = kind, out_tdata = byte, frame length and
//   crc error count, out_tlast = last result of its request.
// cfg_wen/cfg_wdata load the slave address (reset value 1); the user loads it only
//   while idle, which the block does not enforce. A request may be accepted every
//   cycle while the queue is not full; the classifier handles it in the accept
//   cycle (byte-wide crc update) and queues its results. The first result passes
//   the queue slot and the output register before it shows on out_*. Most requests
//   give one result a cycle while out_tready is high; a final outgoing byte gives
//   three (byte, crc low, crc high); short-frame gaps and blocked bytes give none.
// A four-entry queue sits between classifier and output stage; when the
//   receiver stalls, the queue fills and in_tready drops, nothing is lost.
// Synchronous reset blocks reception until the first gap and disallows
//   transmit until a gap; the error count clears.
`default_nettype none

module modbus_rtu_frame_engine #(
  parameter int MAX_FRAME   = mrfe_pkg::MAX_FRAME_DEF,
  parameter int QUEUE_DEPTH = mrfe_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wen,
  input  wire logic [7:0]  cfg_wdata,   // own station address
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // data_byte
  input  wire logic [1:0]  in_tuser,    // opcode
  input  wire logic        in_tlast,    // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,   // out_byte, frame_length, error_total, zero pad
  output logic [2:0]       out_tuser,   // kind
  output logic             out_tlast    // end_mark
);

  mrfe_pkg::rec_t push_data, pop_data;
  logic           q_push, q_pop, q_full, q_empty;
  logic [7:0]     res_byte;
  logic [8:0]     res_len;
  logic [15:0]    res_err;

  mrfe_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .opcode    (in_tuser),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  mrfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  mrfe_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (pop_data),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .kind         (out_tuser),
    .out_byte     (res_byte),
    .frame_length (res_len),
    .error_total  (res_err),
    .end_mark     (out_tlast)
  );

  assign out_tdata = {7'd0, res_err, res_len, res_byte};

endmodule

`default_nettype wire

FILE: design/mrfe_checker.sv
`default_nettype none
`include "assert_macros.svh"

module mrfe_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);

  logic [43:0] out_bus;
  logic [8:0]  len_f;
  logic [15:0] err_f;
  logic        is_byte;
  logic        is_verdict;
  logic        is_crc_err;

  assign out_bus    = {out_tlast, out_tuser, out_tdata};
  assign len_f      = out_tdata[16:8];
  assign err_f      = out_tdata[32:17];
  assign is_byte    = (out_tuser == mrfe_pkg::KIND_RX_BYTE) ||
                      (out_tuser == mrfe_pkg::KIND_TX_BYTE);
  assign is_verdict = (out_tuser == mrfe_pkg::KIND_GOOD) ||
                      (out_tuser == mrfe_pkg::KIND_CRC_ERR);
  assign is_crc_err = (out_tuser == mrfe_pkg::KIND_CRC_ERR);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_bus))

  // byte results carry no frame length
  `ASSERT_SAME(a_byte_no_len, clk, rst_n, out_tvalid && is_byte, len_f == 9'd0)

  // verdicts only for frames longer than the crc itself
  `ASSERT_SAME(a_verdict_len, clk, rst_n, out_tvalid && is_verdict, len_f > 9'd2)

  // a crc error result follows only from a frame that bumped the count, nonzero unless the 16-bit count wraps
  `ASSERT_SAME(a_err_count, clk, rst_n, out_tvalid && is_crc_err, out_tlast && err_f != 16'd0)

endmodule

bind modbus_rtu_frame_engine mrfe_checker u_mrfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
